>>> hw/rtl/lmb_pkg.sv
// Shared types and constants for the level meter ballistics block.
// Holds the configuration struct, register index codes and field widths.
// No dependencies.
package lmb_pkg;

    // Fixed-point formats: levels in 1/2^LEVEL_FRAC_BITS dB, time in 1/2^TIME_FRAC_BITS s
    localparam int LEVEL_FRAC_BITS = 4;
    localparam int TIME_FRAC_BITS  = 10;

    // Field widths
    localparam int LVL_W   = 12;
    localparam int CEIL_W  = 11;
    localparam int IN_W    = 13;
    localparam int DT_W    = 10;
    localparam int RATE_W  = 14;
    localparam int PRATE_W = 12;
    localparam int AGE_W   = 14;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

    // Reset values, written in dB and dB/s where it makes sense
    localparam logic signed [LVL_W-1:0] FLOOR_RESET =
        LVL_W'(-60 * (1 << LEVEL_FRAC_BITS));
    localparam logic signed [CEIL_W-1:0] CEIL_RESET = '0;
    localparam logic [RATE_W-1:0]  RISE_RESET  = RATE_W'(240 * (1 << LEVEL_FRAC_BITS));
    localparam logic [RATE_W-1:0]  FALL_RESET  = RATE_W'(60 * (1 << LEVEL_FRAC_BITS));
    localparam logic [AGE_W-1:0]   HOLD_RESET  = AGE_W'(1 << TIME_FRAC_BITS);
    localparam logic [PRATE_W-1:0] PFALL_RESET = PRATE_W'(20 * (1 << LEVEL_FRAC_BITS));

    // Register index codes (byte address = 4 * index)
    typedef enum logic [2:0] {
        REG_FLOOR      = 3'd0,
        REG_CEILING    = 3'd1,
        REG_RISE_RATE  = 3'd2,
        REG_FALL_RATE  = 3'd3,
        REG_HOLD_TIME  = 3'd4,
        REG_PEAK_FALL  = 3'd5,
        REG_SLEW_EN    = 3'd6,
        REG_HOLD_EN    = 3'd7
    } reg_index_t;

    // Configuration bundle from the register file to the datapath
    typedef struct packed {
        logic signed [LVL_W-1:0]  floor_level;
        logic signed [CEIL_W-1:0] ceiling_level;
        logic [RATE_W-1:0]        rise_rate;
        logic [RATE_W-1:0]        fall_rate;
        logic [AGE_W-1:0]         hold_time;
        logic [PRATE_W-1:0]       peak_fall_rate;
        logic                     slew_enable;
        logic                     hold_enable;
    } cfg_t;

endpackage

>>> hw/rtl/level_meter_ballistics_peak_hold_top.sv
// Top level of the level meter ballistics block with peak hold.
// Depends on lmb_pkg, lmb_cfg_regs and lmb_datapath.
//
// Channel  Direction  Handshake        Payload
// s_       in         s_valid/s_ready  s_level_in, s_level_ok, s_elapsed
// m_       out        m_valid/m_ready  m_shown_level, m_peak_level
// apb      in/out     psel/penable     paddr, pwdata, prdata (pready tied high)
//
// One tick per cycle sustained while m_ready is high; a tick is registered on acceptance
// (input register, then one update through both rate products into the result register).
// Reset (aresetn, synchronous): shown and peak at the floor reset, peak age zero,
// registers at their defaults.
// When m_ready is low the result register holds and one more tick is taken into the
// input register before s_ready drops.
module level_meter_ballistics_peak_hold_top
    import lmb_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [ADDR_W-1:0]       paddr,
    input  logic [DATA_W-1:0]       pwdata,
    output logic [DATA_W-1:0]       prdata,
    output logic                    pready,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [IN_W-1:0]  s_level_in,
    input  logic                    s_level_ok,
    input  logic [DT_W-1:0]         s_elapsed,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [LVL_W-1:0] m_shown_level,
    output logic signed [LVL_W-1:0] m_peak_level
);

    cfg_t cfg;

    // Register file
    lmb_cfg_regs u_cfg_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Ballistics update
    lmb_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_level_in    (s_level_in),
        .s_level_ok    (s_level_ok),
        .s_elapsed     (s_elapsed),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_shown_level (m_shown_level),
        .m_peak_level  (m_peak_level)
    );

endmodule

>>> hw/rtl/lmb_cfg_regs.sv
// APB-style configuration register file for the level meter ballistics block.
// Depends on lmb_pkg (cfg_t, reg_index_t, widths and reset values).
module lmb_cfg_regs
    import lmb_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    reg_index_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_index_t'(paddr[ADDR_W-1:2]);
    assign cfg    = cfg_reg;

    // Register writes on the access phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.floor_level    <= FLOOR_RESET;
            cfg_reg.ceiling_level  <= CEIL_RESET;
            cfg_reg.rise_rate      <= RISE_RESET;
            cfg_reg.fall_rate      <= FALL_RESET;
            cfg_reg.hold_time      <= HOLD_RESET;
            cfg_reg.peak_fall_rate <= PFALL_RESET;
            cfg_reg.slew_enable    <= 1'b1;
            cfg_reg.hold_enable    <= 1'b1;
        end else if (wr_en) begin
            case (idx)
                REG_FLOOR:     cfg_reg.floor_level    <= pwdata[LVL_W-1:0];
                REG_CEILING:   cfg_reg.ceiling_level  <= pwdata[CEIL_W-1:0];
                REG_RISE_RATE: cfg_reg.rise_rate      <= pwdata[RATE_W-1:0];
                REG_FALL_RATE: cfg_reg.fall_rate      <= pwdata[RATE_W-1:0];
                REG_HOLD_TIME: cfg_reg.hold_time      <= pwdata[AGE_W-1:0];
                REG_PEAK_FALL: cfg_reg.peak_fall_rate <= pwdata[PRATE_W-1:0];
                REG_SLEW_EN:   cfg_reg.slew_enable    <= pwdata[0];
                REG_HOLD_EN:   cfg_reg.hold_enable    <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read mux, levels sign-extended
    always_comb begin
        case (idx)
            REG_FLOOR:
                prdata = {{(DATA_W-LVL_W){cfg_reg.floor_level[LVL_W-1]}},
                          cfg_reg.floor_level};
            REG_CEILING:
                prdata = {{(DATA_W-CEIL_W){cfg_reg.ceiling_level[CEIL_W-1]}},
                          cfg_reg.ceiling_level};
            REG_RISE_RATE: prdata = {{(DATA_W-RATE_W){1'b0}}, cfg_reg.rise_rate};
            REG_FALL_RATE: prdata = {{(DATA_W-RATE_W){1'b0}}, cfg_reg.fall_rate};
            REG_HOLD_TIME: prdata = {{(DATA_W-AGE_W){1'b0}}, cfg_reg.hold_time};
            REG_PEAK_FALL: prdata = {{(DATA_W-PRATE_W){1'b0}}, cfg_reg.peak_fall_rate};
            REG_SLEW_EN:   prdata = {{(DATA_W-1){1'b0}}, cfg_reg.slew_enable};
            REG_HOLD_EN:   prdata = {{(DATA_W-1){1'b0}}, cfg_reg.hold_enable};
            default:       prdata = '0;
        endcase
    end

endmodule

>>> hw/rtl/lmb_datapath.sv
// Input register, combinational ballistics update and result register.
// Depends on lmb_pkg (cfg_t, widths, AGE_MAX, TIME_FRAC_BITS, FLOOR_RESET).
module lmb_datapath
    import lmb_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  cfg_t                    cfg,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [IN_W-1:0]  s_level_in,
    input  logic                    s_level_ok,
    input  logic [DT_W-1:0]         s_elapsed,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [LVL_W-1:0] m_shown_level,
    output logic signed [LVL_W-1:0] m_peak_level
);

    // Clamp to [floor, ceiling]; floor test wins
    function automatic logic signed [LVL_W-1:0] clamp_lvl(
        input logic signed [IN_W-1:0] v,
        input cfg_t                   c
    );
        logic signed [IN_W-1:0] lo;
        logic signed [IN_W-1:0] hi;
        lo = $signed({c.floor_level[LVL_W-1], c.floor_level});
        hi = $signed({{(IN_W-CEIL_W){c.ceiling_level[CEIL_W-1]}}, c.ceiling_level});
        if (v < lo)
            return c.floor_level;
        else if (v > hi)
            return $signed({c.ceiling_level[CEIL_W-1], c.ceiling_level});
        else
            return $signed(v[LVL_W-1:0]);
    endfunction

    // Move from toward to by d without overshoot
    function automatic logic signed [LVL_W-1:0] approach(
        input logic signed [LVL_W-1:0] from,
        input logic signed [LVL_W-1:0] to,
        input logic [RATE_W-1:0]       d
    );
        logic signed [15:0] f;
        logic signed [15:0] t;
        logic signed [15:0] dd;
        logic signed [15:0] r;
        f  = $signed({{(16-LVL_W){from[LVL_W-1]}}, from});
        t  = $signed({{(16-LVL_W){to[LVL_W-1]}}, to});
        dd = $signed({{(16-RATE_W){1'b0}}, d});
        if (f < t) begin
            r = f + dd;
            return (r < t) ? $signed(r[LVL_W-1:0]) : to;
        end else begin
            r = f - dd;
            return (r > t) ? $signed(r[LVL_W-1:0]) : to;
        end
    endfunction

    // Input register
    logic                    in_vld_reg;
    logic signed [IN_W-1:0]  level_reg;
    logic                    ok_reg;
    logic [DT_W-1:0]         dt_reg;

    // Meter state
    logic signed [LVL_W-1:0] shown_reg;
    logic signed [LVL_W-1:0] peak_reg;
    logic [AGE_W-1:0]        age_reg;

    // Result register
    logic                    out_vld_reg;
    logic signed [LVL_W-1:0] out_shown_reg;
    logic signed [LVL_W-1:0] out_peak_reg;

    logic                    advance;
    logic signed [LVL_W-1:0] target;
    logic [RATE_W-1:0]       rate_sel;
    logic [RATE_W+DT_W-1:0]  prod_s;
    logic [PRATE_W+DT_W-1:0] prod_p;
    logic [RATE_W-1:0]       step_s;
    logic [PRATE_W-1:0]      step_p;
    logic signed [LVL_W-1:0] shown_raw;
    logic signed [LVL_W-1:0] shown_next;
    logic signed [LVL_W-1:0] peak_raw;
    logic signed [LVL_W-1:0] peak_next;
    logic [AGE_W:0]          age_sum;
    logic [AGE_W-1:0]        age_sat;
    logic [AGE_W-1:0]        age_next;

    assign advance       = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready       = !in_vld_reg || advance;
    assign m_valid       = out_vld_reg;
    assign m_shown_level = out_shown_reg;
    assign m_peak_level  = out_peak_reg;

    // Shown level: target, slew step, clamp
    always_comb begin
        target   = ok_reg ? clamp_lvl(level_reg, cfg) : cfg.floor_level;
        rate_sel = (target > shown_reg) ? cfg.rise_rate : cfg.fall_rate;
        prod_s   = {{DT_W{1'b0}}, rate_sel} * {{RATE_W{1'b0}}, dt_reg};
        step_s   = prod_s[TIME_FRAC_BITS +: RATE_W];
        if (!cfg.slew_enable || dt_reg == '0)
            shown_raw = target;
        else
            shown_raw = approach(shown_reg, target, step_s);
        shown_next = clamp_lvl($signed({shown_raw[LVL_W-1], shown_raw}), cfg);
    end

    // Peak level: follow rises, age, then fall after hold; with hold off it tracks the shown level
    always_comb begin
        prod_p  = {{DT_W{1'b0}}, cfg.peak_fall_rate} * {{PRATE_W{1'b0}}, dt_reg};
        step_p  = prod_p[TIME_FRAC_BITS +: PRATE_W];
        age_sum = {1'b0, age_reg} + {{(AGE_W+1-DT_W){1'b0}}, dt_reg};
        age_sat = age_sum[AGE_W] ? AGE_MAX : age_sum[AGE_W-1:0];
        peak_raw  = peak_reg;
        peak_next = shown_next;
        age_next  = '0;
        if (cfg.hold_enable) begin
            if (shown_next >= peak_reg) begin
                peak_raw = shown_next;
            end else begin
                age_next = age_sat;
                if (age_sat > cfg.hold_time)
                    peak_raw = approach(peak_reg, shown_next,
                                        {{(RATE_W-PRATE_W){1'b0}}, step_p});
            end
            peak_next = clamp_lvl($signed({peak_raw[LVL_W-1], peak_raw}), cfg);
        end
    end

    // Control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            shown_reg   <= FLOOR_RESET;
            peak_reg    <= FLOOR_RESET;
            age_reg     <= '0;
        end else begin
            if (s_valid && s_ready)
                in_vld_reg <= 1'b1;
            else if (advance)
                in_vld_reg <= 1'b0;

            if (advance)
                out_vld_reg <= 1'b1;
            else if (m_ready)
                out_vld_reg <= 1'b0;

            if (advance) begin
                shown_reg <= shown_next;
                peak_reg  <= peak_next;
                age_reg   <= age_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            level_reg <= s_level_in;
            ok_reg    <= s_level_ok;
            dt_reg    <= s_elapsed;
        end
        if (advance) begin
            out_shown_reg <= shown_next;
            out_peak_reg  <= peak_next;
        end
    end

    // A waiting result stays put until it is taken
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=>
            (m_valid && $stable(m_shown_level) && $stable(m_peak_level)))
        else $error("waiting result changed");

    // A finished update always produces a pending result
    a_advance_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_vld_reg)
        else $error("update without result");

    // Hold off keeps the peak age at zero
    a_age_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !cfg.hold_enable) |=> (age_reg == '0))
        else $error("peak age not cleared with hold off");

    // Input stalls only when both registers are full and the output is blocked
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_vld_reg && out_vld_reg && !m_ready))
        else $error("input stalled without cause");

endmodule
